// ===== hw/rtl/voice_activity_state_machine_assert.svh =====
// Assertion macros used by the checker file of this block.
`ifndef VOICE_ACTIVITY_STATE_MACHINE_ASSERT_SVH
`define VOICE_ACTIVITY_STATE_MACHINE_ASSERT_SVH

// Clocked assertion that is switched off while reset is high.
`define VASM_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("vasm assertion failed");

// Clocked assertion that also holds across reset.
`define VASM_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("vasm assertion failed");

`endif

// ===== hw/rtl/vasm_pkg.sv =====
`default_nettype none

package vasm_pkg;

  // Internal widths of the identifier counter and the millisecond clock.
  localparam int ID_BITS   = 16;
  localparam int TIME_BITS = 32;

  // Fixed field widths.
  localparam int PROB_BITS     = 16;
  localparam int DWELL_BITS    = 16;
  localparam int MAX_UTT_BITS  = 20;
  localparam int NOW_BITS      = 32;
  localparam int OUT_ID_BITS   = 16;
  localparam int COUNT_BITS    = 16;
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 20;

  // Widths used for the dwell and utterance length compares.
  localparam int DWELL_CMP_BITS = (TIME_BITS > DWELL_BITS) ? TIME_BITS : DWELL_BITS;
  localparam int UTT_CMP_BITS   = (TIME_BITS > MAX_UTT_BITS) ? TIME_BITS : MAX_UTT_BITS;

  // Dwell tolerances subtracted from the minimum dwell settings.
  localparam logic [DWELL_BITS-1:0] SPEECH_TOL  = DWELL_BITS'(10);
  localparam logic [DWELL_BITS-1:0] SILENCE_TOL = DWELL_BITS'(50);

  // Configuration register indexes.
  localparam logic [CFG_IDX_BITS-1:0] CFG_SPEECH_THR  = CFG_IDX_BITS'(0);
  localparam logic [CFG_IDX_BITS-1:0] CFG_SILENCE_THR = CFG_IDX_BITS'(1);
  localparam logic [CFG_IDX_BITS-1:0] CFG_MIN_SPEECH  = CFG_IDX_BITS'(2);
  localparam logic [CFG_IDX_BITS-1:0] CFG_MIN_SILENCE = CFG_IDX_BITS'(3);
  localparam logic [CFG_IDX_BITS-1:0] CFG_MAX_UTT     = CFG_IDX_BITS'(4);

  // Action codes carried by an input transaction.
  localparam logic [1:0] ACT_SAMPLE    = 2'd0;
  localparam logic [1:0] ACT_FORCE_END = 2'd1;
  localparam logic [1:0] ACT_RESET     = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE     = 2'd0,
    ST_DETECTED = 2'd1,
    ST_SPEAKING = 2'd2,
    ST_PAUSE    = 2'd3
  } state_t;

  typedef struct packed {
    logic [PROB_BITS-1:0]    speech_thr;
    logic [PROB_BITS-1:0]    silence_thr;
    logic [DWELL_BITS-1:0]   min_speech;
    logic [DWELL_BITS-1:0]   min_silence;
    logic [MAX_UTT_BITS-1:0] max_utt;
  } cfg_t;

  typedef struct packed {
    logic [1:0]           action;
    logic [PROB_BITS-1:0] prob;
    logic [NOW_BITS-1:0]  now;
  } item_t;

  typedef struct packed {
    state_t                 vad_state;
    state_t                 previous_state;
    logic                   state_changed;
    logic [PROB_BITS-1:0]   event_confidence;
    logic [OUT_ID_BITS-1:0] active_utterance;
    logic                   utterance_ended;
    logic [OUT_ID_BITS-1:0] ended_utterance;
    logic [COUNT_BITS-1:0]  utterance_total;
  } result_t;

endpackage

`default_nettype wire

// ===== hw/rtl/vasm_cfg_regs.sv =====
`default_nettype none

module vasm_cfg_regs (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 cfg_write,
  input  wire logic [vasm_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  wire logic [vasm_pkg::CFG_DATA_BITS-1:0]   cfg_data,
  output vasm_pkg::cfg_t                            cfg
);
  import vasm_pkg::*;

  // Register file with the documented reset values; unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.speech_thr  <= PROB_BITS'(32768);
      cfg.silence_thr <= PROB_BITS'(19661);
      cfg.min_speech  <= DWELL_BITS'(250);
      cfg.min_silence <= DWELL_BITS'(500);
      cfg.max_utt     <= MAX_UTT_BITS'(30000);
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_SPEECH_THR:  cfg.speech_thr  <= cfg_data[PROB_BITS-1:0];
        CFG_SILENCE_THR: cfg.silence_thr <= cfg_data[PROB_BITS-1:0];
        CFG_MIN_SPEECH:  cfg.min_speech  <= cfg_data[DWELL_BITS-1:0];
        CFG_MIN_SILENCE: cfg.min_silence <= cfg_data[DWELL_BITS-1:0];
        CFG_MAX_UTT:     cfg.max_utt     <= cfg_data[MAX_UTT_BITS-1:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/vasm_in_reg.sv =====
`default_nettype none

module vasm_in_reg (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire vasm_pkg::item_t item_in,
  input  wire logic            advance,
  output logic                 item_valid,
  output vasm_pkg::item_t      item
);
  import vasm_pkg::*;

  // The register takes a new transaction when empty or when its content moves on.
  assign in_ready = !item_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= in_valid;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item <= item_in;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/vasm_core.sv =====
`default_nettype none

module vasm_core (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire vasm_pkg::cfg_t  cfg,
  input  wire vasm_pkg::item_t item,
  input  wire logic            advance,
  output vasm_pkg::result_t    result
);
  import vasm_pkg::*;

  state_t                 fsm_state;
  logic [ID_BITS-1:0]     active_id;
  logic [ID_BITS-1:0]     next_id;
  logic [TIME_BITS-1:0]   change_time;
  logic [TIME_BITS-1:0]   start_time;
  logic [COUNT_BITS-1:0]  closed_count;

  state_t                 target;
  logic                   event_hit;
  logic                   conf_sel;
  logic [TIME_BITS-1:0]   now;
  logic [TIME_BITS-1:0]   since_change;
  logic [TIME_BITS-1:0]   since_start;
  logic                   speech;
  logic                   silence;
  logic                   too_long;
  logic                   speech_dwell_ok;
  logic                   silence_dwell_ok;
  logic                   opening;
  logic                   closing;
  logic [ID_BITS-1:0]     id_inc;
  logic [ID_BITS-1:0]     active_id_next;
  logic [ID_BITS-1:0]     next_id_next;
  logic [TIME_BITS-1:0]   start_time_next;
  logic [COUNT_BITS-1:0]  closed_count_next;

  // Threshold and elapsed time checks on the current sample.
  assign now          = TIME_BITS'(item.now);
  assign since_change = now - change_time;
  assign since_start  = now - start_time;
  assign speech       = item.prob > cfg.speech_thr;
  assign silence      = item.prob < cfg.silence_thr;
  assign too_long     = UTT_CMP_BITS'(since_start) > UTT_CMP_BITS'(cfg.max_utt);

  // A setting below its tolerance gives a negative minimum, which always passes.
  assign speech_dwell_ok = (cfg.min_speech < SPEECH_TOL) ||
      (DWELL_CMP_BITS'(since_change) >= DWELL_CMP_BITS'(cfg.min_speech - SPEECH_TOL));
  assign silence_dwell_ok = (cfg.min_silence < SILENCE_TOL) ||
      (DWELL_CMP_BITS'(since_change) >= DWELL_CMP_BITS'(cfg.min_silence - SILENCE_TOL));

  // Next state and whether this transaction is a transition event.
  always_comb begin
    target    = fsm_state;
    event_hit = 1'b0;
    conf_sel  = 1'b0;
    unique case (item.action)
      ACT_SAMPLE: begin
        unique case (fsm_state)
          ST_IDLE: begin
            if (speech) target = ST_DETECTED;
          end
          ST_DETECTED: begin
            priority if (!speech && silence) target = ST_IDLE;
            else if (speech_dwell_ok)        target = ST_SPEAKING;
            else                             target = fsm_state;
          end
          ST_SPEAKING: begin
            priority if (too_long) target = ST_IDLE;
            else if (silence)      target = ST_PAUSE;
            else                   target = fsm_state;
          end
          ST_PAUSE: begin
            priority if (too_long)     target = ST_IDLE;
            else if (speech)           target = ST_SPEAKING;
            else if (silence_dwell_ok) target = ST_IDLE;
            else                       target = fsm_state;
          end
          default: ;
        endcase
        event_hit = (target != fsm_state);
        conf_sel  = event_hit;
      end
      ACT_FORCE_END: begin
        if (fsm_state == ST_SPEAKING || fsm_state == ST_PAUSE) begin
          target    = ST_IDLE;
          event_hit = 1'b1;
        end
      end
      ACT_RESET: begin
        target    = ST_IDLE;
        event_hit = 1'b1;
      end
      default: ;
    endcase
  end

  // Utterance bookkeeping that follows from the event.
  always_comb begin
    opening = event_hit && (target == ST_SPEAKING) && (active_id == '0);
    closing = event_hit && (target == ST_IDLE) && (active_id != '0) &&
              (fsm_state == ST_SPEAKING || fsm_state == ST_PAUSE);
    id_inc  = next_id + ID_BITS'(1);

    active_id_next    = active_id;
    next_id_next      = next_id;
    start_time_next   = start_time;
    closed_count_next = closed_count;
    if (opening) begin
      active_id_next  = next_id;
      next_id_next    = (id_inc == '0) ? ID_BITS'(1) : id_inc;
      start_time_next = now;
    end
    if (closing) begin
      active_id_next    = '0;
      closed_count_next = closed_count + COUNT_BITS'(1);
    end

    result.vad_state        = target;
    result.previous_state   = fsm_state;
    result.state_changed    = event_hit;
    result.event_confidence = conf_sel ? item.prob : '0;
    result.active_utterance = OUT_ID_BITS'(active_id_next);
    result.utterance_ended  = closing;
    result.ended_utterance  = closing ? OUT_ID_BITS'(active_id) : '0;
    result.utterance_total  = closed_count_next;
  end

  // State registers advance once per processed transaction.
  always_ff @(posedge clk) begin
    if (rst) begin
      fsm_state    <= ST_IDLE;
      active_id    <= '0;
      next_id      <= ID_BITS'(1);
      change_time  <= '0;
      start_time   <= '0;
      closed_count <= '0;
    end else if (advance) begin
      fsm_state    <= target;
      active_id    <= active_id_next;
      next_id      <= next_id_next;
      start_time   <= start_time_next;
      closed_count <= closed_count_next;
      if (event_hit) begin
        change_time <= now;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/vasm_out_reg.sv =====
`default_nettype none

module vasm_out_reg (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              item_valid,
  output logic                   advance,
  input  wire vasm_pkg::result_t result_in,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output vasm_pkg::result_t      result
);
  import vasm_pkg::*;

  // A result moves in when the register is empty or is being drained this cycle.
  assign advance = item_valid && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result <= result_in;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/voice_activity_state_machine.sv =====
// Voice activity tracker: one result transaction per input transaction.
// The input and result registers decouple the two sides; each input passes through both in turn.
// Throughput: one transaction per cycle unless the receiver stalls the result register.
// Reset (synchronous, active high): state idle, no utterance, next identifier one,
// times and count zero, configuration back to its defaults, both channels empty.
`default_nettype none

module voice_activity_state_machine (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_write,
  input  wire logic [vasm_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  wire logic [vasm_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic [1:0]                          action,
  input  wire logic [vasm_pkg::PROB_BITS-1:0]      speech_probability,
  input  wire logic [vasm_pkg::NOW_BITS-1:0]       now_ms,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic [1:0]                               vad_state,
  output logic [1:0]                               previous_state,
  output logic                                     state_changed,
  output logic [vasm_pkg::PROB_BITS-1:0]           event_confidence,
  output logic [vasm_pkg::OUT_ID_BITS-1:0]         active_utterance,
  output logic                                     utterance_ended,
  output logic [vasm_pkg::OUT_ID_BITS-1:0]         ended_utterance,
  output logic [vasm_pkg::COUNT_BITS-1:0]          utterance_total
);
  import vasm_pkg::*;

  cfg_t    cfg;
  item_t   item_in;
  item_t   item;
  logic    item_valid;
  logic    advance;
  result_t core_result;
  result_t result;

  assign item_in.action = action;
  assign item_in.prob   = speech_probability;
  assign item_in.now    = now_ms;

  vasm_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  vasm_in_reg u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .item_in    (item_in),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  vasm_core u_core (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .item    (item),
    .advance (advance),
    .result  (core_result)
  );

  vasm_out_reg u_out (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .advance    (advance),
    .result_in  (core_result),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .result     (result)
  );

  // Unpack the registered result onto the output fields.
  assign vad_state        = result.vad_state;
  assign previous_state   = result.previous_state;
  assign state_changed    = result.state_changed;
  assign event_confidence = result.event_confidence;
  assign active_utterance = result.active_utterance;
  assign utterance_ended  = result.utterance_ended;
  assign ended_utterance  = result.ended_utterance;
  assign utterance_total  = result.utterance_total;

endmodule

`default_nettype wire

// ===== hw/rtl/vasm_checker.sv =====
`default_nettype none

`include "voice_activity_state_machine_assert.svh"

module vasm_checker (
  input wire logic                                clk,
  input wire logic                                rst,
  input wire logic                                out_valid,
  input wire logic                                out_ready,
  input wire logic [1:0]                          vad_state,
  input wire logic [1:0]                          previous_state,
  input wire logic                                state_changed,
  input wire logic [vasm_pkg::PROB_BITS-1:0]      event_confidence,
  input wire logic [vasm_pkg::OUT_ID_BITS-1:0]    active_utterance,
  input wire logic                                utterance_ended
);
  import vasm_pkg::*;

  // A stalled result holds its state field.
  `VASM_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(vad_state))

  // Without a transition event the state stays and no confidence is reported.
  `VASM_ASSERT(a_no_event, out_valid && !state_changed |-> vad_state == previous_state && event_confidence == '0)

  // A closed utterance always leaves the machine idle with no active identifier.
  `VASM_ASSERT(a_close_idle, out_valid && utterance_ended |-> vad_state == ST_IDLE && active_utterance == '0)

  // An identifier is active exactly while speaking or in a pause.
  `VASM_ASSERT(a_active_state, out_valid |-> (active_utterance != '0) == (vad_state == ST_SPEAKING || vad_state == ST_PAUSE))

  // Reset empties the result register.
  `VASM_ASSERT_ALWAYS(a_reset_empty, rst |=> !out_valid)

endmodule

bind voice_activity_state_machine vasm_checker u_vasm_checker (
  .clk              (clk),
  .rst              (rst),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .vad_state        (vad_state),
  .previous_state   (previous_state),
  .state_changed    (state_changed),
  .event_confidence (event_confidence),
  .active_utterance (active_utterance),
  .utterance_ended  (utterance_ended)
);

`default_nettype wire

// ===== verif/voice_activity_state_machine_tb.sv =====
`timescale 1ns / 100ps

module voice_activity_state_machine_tb;
  import vasm_pkg::*;

  // Action code that the block must ignore, and a register index that it must ignore.
  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam logic [CFG_IDX_BITS-1:0] CFG_UNUSED_IDX = CFG_IDX_BITS'(7);

  localparam int TIMEOUT_NS    = 20_000_000;
  localparam int SETTLE_CYCLES = 4;
  localparam int MAX_REPORTS   = 10;
  localparam int ID_ROUNDS     = 20;

  typedef enum {PK_SPEECH, PK_SILENCE, PK_ANY, PK_EDGE} prob_kind_t;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     cfg_write = 1'b0;
  logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data = '0;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic [1:0]               action = ACT_SAMPLE;
  logic [PROB_BITS-1:0]     speech_probability = '0;
  logic [NOW_BITS-1:0]      now_ms = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic [1:0]               vad_state;
  logic [1:0]               previous_state;
  logic                     state_changed;
  logic [PROB_BITS-1:0]     event_confidence;
  logic [OUT_ID_BITS-1:0]   active_utterance;
  logic                     utterance_ended;
  logic [OUT_ID_BITS-1:0]   ended_utterance;
  logic [COUNT_BITS-1:0]    utterance_total;

  // Configuration as the tracker currently sees it.
  logic [PROB_BITS-1:0]    thr_speech    = 16'd32768;
  logic [PROB_BITS-1:0]    thr_silence   = 16'd19661;
  logic [DWELL_BITS-1:0]   dwell_speech  = 16'd250;
  logic [DWELL_BITS-1:0]   dwell_silence = 16'd500;
  logic [MAX_UTT_BITS-1:0] utt_limit     = 20'd30000;

  // Tracker state mirrored by the predictor.
  state_t                  vad_cur    = ST_IDLE;
  logic [ID_BITS-1:0]      utt_active = '0;
  logic [ID_BITS-1:0]      utt_next   = 16'd1;
  logic [TIME_BITS-1:0]    t_change   = '0;
  logic [TIME_BITS-1:0]    t_start    = '0;
  logic [COUNT_BITS-1:0]   utt_count  = '0;

  result_t                 vad_results_due[$];
  int                      mismatch_count = 0;
  int                      items_sent = 0;
  int                      send_idle_pct = 0;
  int                      stall_pct = 0;
  logic [NOW_BITS-1:0]     wall_ms = '0;

  voice_activity_state_machine dut (
    .clk                (clk),
    .rst                (rst),
    .cfg_write          (cfg_write),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .action             (action),
    .speech_probability (speech_probability),
    .now_ms             (now_ms),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .vad_state          (vad_state),
    .previous_state     (previous_state),
    .state_changed      (state_changed),
    .event_confidence   (event_confidence),
    .active_utterance   (active_utterance),
    .utterance_ended    (utterance_ended),
    .ended_utterance    (ended_utterance),
    .utterance_total    (utterance_total)
  );

  always #5 clk = ~clk;

  // The receiver stalls at random; the stall rate follows the current phase.
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  // A negative dwell requirement always passes; otherwise the wrapping time since the
  // last change must reach the setting minus its tolerance.
  function automatic logic dwell_met(input logic [TIME_BITS-1:0] t,
                                     input logic [DWELL_BITS-1:0] setting,
                                     input logic [DWELL_BITS-1:0] tol);
    logic [TIME_BITS-1:0] held;
    held = t - t_change;
    if (setting < tol) return 1'b1;
    return held >= TIME_BITS'(setting - tol);
  endfunction

  // Moves the tracker to a new state, opening or closing an utterance as needed.
  function automatic void enter_state(input state_t goal, input state_t was,
                                      input logic [TIME_BITS-1:0] t, inout result_t r);
    vad_cur = goal;
    t_change = t;
    if (goal == ST_SPEAKING) begin
      if (utt_active == '0) begin
        utt_active = utt_next;
        utt_next = utt_next + 1'b1;
        if (utt_next == '0) utt_next = 1;
        t_start = t;
      end
    end else if (goal == ST_IDLE && (was == ST_SPEAKING || was == ST_PAUSE) &&
                 utt_active != '0) begin
      r.utterance_ended = 1'b1;
      r.ended_utterance = utt_active;
      utt_count = utt_count + 1'b1;
      utt_active = '0;
    end
  endfunction

  // Advances the tracker by one input transaction and returns the result it must report.
  function automatic result_t predict_vad(input logic [1:0] act,
                                          input logic [PROB_BITS-1:0] prob,
                                          input logic [NOW_BITS-1:0] t);
    result_t r;
    state_t was;
    state_t goal;
    logic is_speech;
    logic is_silence;
    logic too_long;
    logic [TIME_BITS-1:0] since_start;
    r = '0;
    was = vad_cur;
    goal = was;
    r.previous_state = was;
    since_start = t - t_start;
    is_speech = prob > thr_speech;
    is_silence = prob < thr_silence;
    too_long = since_start > TIME_BITS'(utt_limit);
    if (act == ACT_SAMPLE) begin
      case (was)
        ST_IDLE: begin
          if (is_speech) goal = ST_DETECTED;
        end
        ST_DETECTED: begin
          if (!is_speech && is_silence) goal = ST_IDLE;
          else if (dwell_met(t, dwell_speech, SPEECH_TOL)) goal = ST_SPEAKING;
        end
        ST_SPEAKING: begin
          if (too_long) goal = ST_IDLE;
          else if (is_silence) goal = ST_PAUSE;
        end
        default: begin
          if (too_long) goal = ST_IDLE;
          else if (is_speech) goal = ST_SPEAKING;
          else if (dwell_met(t, dwell_silence, SILENCE_TOL)) goal = ST_IDLE;
        end
      endcase
      if (goal != was) begin
        r.state_changed = 1'b1;
        r.event_confidence = prob;
        enter_state(goal, was, t, r);
      end
    end else if (act == ACT_FORCE_END) begin
      if (was == ST_SPEAKING || was == ST_PAUSE) begin
        r.state_changed = 1'b1;
        enter_state(ST_IDLE, was, t, r);
      end
    end else if (act == ACT_RESET) begin
      r.state_changed = 1'b1;
      enter_state(ST_IDLE, was, t, r);
    end
    r.vad_state = vad_cur;
    r.active_utterance = utt_active;
    r.utterance_total = utt_count;
    return r;
  endfunction

  // Compares every result transaction with the oldest expectation.
  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (!rst && out_valid && out_ready) begin
      got.vad_state        = state_t'(vad_state);
      got.previous_state   = state_t'(previous_state);
      got.state_changed    = state_changed;
      got.event_confidence = event_confidence;
      got.active_utterance = active_utterance;
      got.utterance_ended  = utterance_ended;
      got.ended_utterance  = ended_utterance;
      got.utterance_total  = utterance_total;
      if (vad_results_due.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("%0t: result transaction with nothing expected", $realtime);
      end else begin
        want = vad_results_due.pop_front();
        if (got.vad_state !== want.vad_state ||
            got.previous_state !== want.previous_state ||
            got.state_changed !== want.state_changed ||
            got.event_confidence !== want.event_confidence ||
            got.active_utterance !== want.active_utterance ||
            got.utterance_ended !== want.utterance_ended ||
            got.ended_utterance !== want.ended_utterance ||
            got.utterance_total !== want.utterance_total) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS) begin
            $display("%0t: expected state %0d prev %0d chg %0b conf %0d id %0d end %0b %0d tot %0d",
                     $realtime, want.vad_state, want.previous_state, want.state_changed,
                     want.event_confidence, want.active_utterance, want.utterance_ended,
                     want.ended_utterance, want.utterance_total);
            $display("%0t: actual   state %0d prev %0d chg %0b conf %0d id %0d end %0b %0d tot %0d",
                     $realtime, got.vad_state, got.previous_state, got.state_changed,
                     got.event_confidence, got.active_utterance, got.utterance_ended,
                     got.ended_utterance, got.utterance_total);
          end
        end
      end
    end
  end

  // Offers one input transaction, after a random gap, and records its expected result.
  task automatic send_item(input logic [1:0] act, input logic [PROB_BITS-1:0] prob,
                           input logic [NOW_BITS-1:0] t);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    action <= act;
    speech_probability <= prob;
    now_ms <= t;
    do @(posedge clk); while (!in_ready);
    vad_results_due.push_back(predict_vad(act, prob, t));
    if (act != ACT_UNUSED) items_sent++;
  endtask

  // Holds the sender off until every outstanding result has arrived.
  task automatic wait_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (vad_results_due.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Writes one register; the caller makes sure the block is idle.
  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] val);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_write <= 1'b0;
    case (idx)
      CFG_SPEECH_THR:  thr_speech = val[PROB_BITS-1:0];
      CFG_SILENCE_THR: thr_silence = val[PROB_BITS-1:0];
      CFG_MIN_SPEECH:  dwell_speech = val[DWELL_BITS-1:0];
      CFG_MIN_SILENCE: dwell_silence = val[DWELL_BITS-1:0];
      CFG_MAX_UTT:     utt_limit = val[MAX_UTT_BITS-1:0];
      default: ;
    endcase
  endtask

  // Time steps span short windows, dwell settings, the utterance limit and wild jumps.
  function automatic logic [NOW_BITS-1:0] pick_step();
    int unsigned sel;
    int unsigned span;
    sel = $urandom_range(99);
    span = (dwell_speech > dwell_silence) ? dwell_speech : dwell_silence;
    if (sel < 10) return '0;
    if (sel < 50) return $urandom_range(40, 1);
    if (sel < 85) return $urandom_range(span + 20, 0);
    if (sel < 97) return $urandom_range(utt_limit + 100, 0);
    return $urandom();
  endfunction

  // Probabilities are chosen relative to the current thresholds.
  function automatic logic [PROB_BITS-1:0] pick_prob(input prob_kind_t kind);
    case (kind)
      PK_SPEECH: begin
        if (thr_speech == '1) return '1;
        return PROB_BITS'($urandom_range(32'hFFFF, 32'(thr_speech) + 1));
      end
      PK_SILENCE: begin
        if (thr_silence == '0) return '0;
        return PROB_BITS'($urandom_range(32'(thr_silence) - 1, 0));
      end
      PK_EDGE: begin
        case ($urandom_range(5))
          0: return thr_speech;
          1: return thr_speech + 1'b1;
          2: return thr_silence;
          3: return thr_silence - 1'b1;
          4: return '0;
          default: return '1;
        endcase
      end
      default: return PROB_BITS'($urandom());
    endcase
  endfunction

  task automatic send_timed(input logic [1:0] act, input logic [PROB_BITS-1:0] prob);
    wall_ms = wall_ms + pick_step();
    send_item(act, prob, wall_ms);
  endtask

  // One utterance: bursts of speech and silence, sometimes cut short by a force end or reset.
  task automatic send_utterance();
    int rounds;
    rounds = $urandom_range(2, 1);
    repeat (rounds) begin
      repeat ($urandom_range(6, 1))
        send_timed(ACT_SAMPLE, pick_prob(($urandom_range(6) == 0) ? PK_EDGE : PK_SPEECH));
      if ($urandom_range(3) == 0) send_timed(ACT_SAMPLE, pick_prob(PK_ANY));
      repeat ($urandom_range(8, 1))
        send_timed(ACT_SAMPLE, pick_prob(($urandom_range(6) == 0) ? PK_EDGE : PK_SILENCE));
    end
    case ($urandom_range(7))
      0: send_timed(ACT_FORCE_END, pick_prob(PK_ANY));
      1: send_timed(ACT_RESET, pick_prob(PK_ANY));
      default: ;
    endcase
  endtask

  // Mostly well-formed utterances, with some noise and an occasional full drain.
  task automatic run_traffic(input int target);
    int first;
    first = items_sent;
    while (items_sent - first < target) begin
      if ($urandom_range(99) < 80) send_utterance();
      else send_timed(2'($urandom_range(3, 0)), pick_prob(($urandom_range(1) == 0) ? PK_ANY : PK_EDGE));
      if ($urandom_range(39) == 0) wait_results();
    end
    wait_results();
  endtask

  // Walks every transition under the reset configuration, including time wrap.
  task automatic test_directed_transitions();
    send_idle_pct = 0;
    stall_pct = 0;
    send_item(ACT_SAMPLE, 16'd0, 32'd0);
    send_item(ACT_UNUSED, 16'hFFFF, 32'hFFFF_FFFF);
    send_item(ACT_FORCE_END, 16'd1234, 32'd5);
    send_item(ACT_RESET, 16'd0, 32'd10);
    send_item(ACT_SAMPLE, 16'd32768, 32'd20);
    send_item(ACT_SAMPLE, 16'd32769, 32'd30);
    send_item(ACT_SAMPLE, 16'd25000, 32'd100);
    send_item(ACT_SAMPLE, 16'd19660, 32'd120);
    send_item(ACT_SAMPLE, 16'hFFFF, 32'd200);
    send_item(ACT_SAMPLE, 16'd19661, 32'd439);
    send_item(ACT_SAMPLE, 16'd19661, 32'd440);
    send_item(ACT_SAMPLE, 16'd0, 32'd600);
    send_item(ACT_SAMPLE, 16'd40000, 32'd650);
    send_item(ACT_SAMPLE, 16'd100, 32'd700);
    send_item(ACT_SAMPLE, 16'd25000, 32'd1149);
    send_item(ACT_SAMPLE, 16'd25000, 32'd1150);
    // Dwell measured across the wrap of the millisecond clock.
    send_item(ACT_SAMPLE, 16'hFFFF, 32'hFFFF_FF80);
    send_item(ACT_SAMPLE, 16'hFFFF, 32'h0000_0070);
    send_item(ACT_FORCE_END, 16'hFFFF, 32'h0000_0080);
    // Utterance limit reached in pause and then in speaking.
    send_item(ACT_SAMPLE, 16'hFFFF, 32'd1000);
    send_item(ACT_SAMPLE, 16'hFFFF, 32'd1240);
    send_item(ACT_SAMPLE, 16'd0, 32'd1300);
    send_item(ACT_SAMPLE, 16'd25000, 32'd31241);
    send_item(ACT_SAMPLE, 16'hFFFF, 32'd40000);
    send_item(ACT_SAMPLE, 16'hFFFF, 32'd40240);
    send_item(ACT_SAMPLE, 16'hFFFF, 32'd70241);
    // Reset out of speaking closes the utterance.
    send_item(ACT_SAMPLE, 16'hFFFF, 32'd80000);
    send_item(ACT_SAMPLE, 16'hFFFF, 32'd80240);
    send_item(ACT_RESET, 16'hFFFF, 32'd80250);
    wait_results();
  endtask

  task automatic test_default_traffic();
    send_idle_pct = 0;
    stall_pct = 0;
    wall_ms = $urandom();
    run_traffic(250);
  endtask

  // Lowest settings but the highest silence threshold; an unused register index must change nothing.
  task automatic test_open_thresholds();
    send_idle_pct = 64;
    stall_pct = 0;
    write_reg(CFG_SPEECH_THR, '0);
    write_reg(CFG_SILENCE_THR, 20'hFFFF);
    write_reg(CFG_MIN_SPEECH, '0);
    write_reg(CFG_MIN_SILENCE, '0);
    write_reg(CFG_MAX_UTT, '0);
    write_reg(CFG_UNUSED_IDX, '1);
    wall_ms = $urandom();
    run_traffic(200);
  endtask

  // Highest dwell and utterance settings, then thresholds nothing can cross and dwells at their tolerances.
  task automatic test_long_dwell();
    send_idle_pct = 0;
    stall_pct = 64;
    write_reg(CFG_SPEECH_THR, 20'd40000);
    write_reg(CFG_SILENCE_THR, 20'd10000);
    write_reg(CFG_MIN_SPEECH, 20'hFFFF);
    write_reg(CFG_MIN_SILENCE, 20'hFFFF);
    write_reg(CFG_MAX_UTT, 20'hFFFFF);
    wall_ms = 32'hFFF0_0000;
    run_traffic(250);
    write_reg(CFG_SPEECH_THR, 20'hFFFF);
    write_reg(CFG_SILENCE_THR, '0);
    write_reg(CFG_MIN_SPEECH, 20'd10);
    write_reg(CFG_MIN_SILENCE, 20'd50);
    run_traffic(60);
  endtask

  // Dwell settings below and exactly at their tolerances.
  task automatic test_short_dwell();
    send_idle_pct = 35;
    stall_pct = 35;
    write_reg(CFG_SPEECH_THR, CFG_DATA_BITS'($urandom_range(32'hFFFF, 0)));
    write_reg(CFG_SILENCE_THR, CFG_DATA_BITS'($urandom_range(32'hFFFF, 0)));
    write_reg(CFG_MIN_SPEECH, CFG_DATA_BITS'($urandom_range(9, 0)));
    write_reg(CFG_MIN_SILENCE, CFG_DATA_BITS'($urandom_range(49, 0)));
    write_reg(CFG_MAX_UTT, CFG_DATA_BITS'($urandom_range(2000, 0)));
    wall_ms = $urandom();
    run_traffic(120);
    write_reg(CFG_SPEECH_THR, 20'd32768);
    write_reg(CFG_SILENCE_THR, 20'd19661);
    write_reg(CFG_MIN_SPEECH, 20'd10);
    write_reg(CFG_MIN_SILENCE, 20'd50);
    write_reg(CFG_MAX_UTT, 20'd1000);
    run_traffic(120);
  endtask

  // Back-to-back utterances, each opened and closed, step the identifier and the closed count.
  task automatic test_identifier_sequence();
    send_idle_pct = 0;
    stall_pct = 0;
    write_reg(CFG_SPEECH_THR, 20'd32768);
    write_reg(CFG_MIN_SPEECH, '0);
    write_reg(CFG_MAX_UTT, 20'hFFFFF);
    send_item(ACT_RESET, '0, wall_ms);
    repeat (ID_ROUNDS) begin
      wall_ms = wall_ms + 1'b1;
      send_item(ACT_SAMPLE, 16'hFFFF, wall_ms);
      send_item(ACT_SAMPLE, 16'hFFFF, wall_ms);
      send_item(ACT_FORCE_END, '0, wall_ms);
    end
    wait_results();
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed_transitions();
    test_default_traffic();
    test_open_thresholds();
    test_long_dwell();
    test_short_dwell();
    test_identifier_sequence();
    if (mismatch_count == 0 && vad_results_due.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Guards against a hung handshake.
  initial begin
    #(TIMEOUT_NS);
    $display("Mismatches found");
    $finish;
  end

endmodule

// ===== voice_activity_state_machine.f =====
+incdir+hw/rtl
hw/rtl/vasm_pkg.sv
hw/rtl/vasm_cfg_regs.sv
hw/rtl/vasm_in_reg.sv
hw/rtl/vasm_core.sv
hw/rtl/vasm_out_reg.sv
hw/rtl/voice_activity_state_machine.sv
hw/rtl/vasm_checker.sv
verif/voice_activity_state_machine_tb.sv
